// ===== design/critically_damped_smoothing_2d_macros.svh =====
// ----------------------------------------------------------------------------
// critically_damped_smoothing_2d_macros.svh
// Assertion helpers for the smoothing block.
// ----------------------------------------------------------------------------
`ifndef CRITICALLY_DAMPED_SMOOTHING_2D_MACROS_SVH
`define CRITICALLY_DAMPED_SMOOTHING_2D_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cds2d_pkg.sv =====
// ----------------------------------------------------------------------------
// cds2d_pkg
// Types and constants shared by the 2D smoothing block.
// ----------------------------------------------------------------------------
package cds2d_pkg;

  localparam int unsigned UqW     = 31;
  localparam int unsigned DtW     = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CntW    = 7;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SMOOTH_TIME = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED   = 1'd1;

  localparam logic [UqW-1:0] SMOOTH_RESET = 31'd65536;
  localparam logic [UqW-1:0] SPEED_RESET  = 31'h7FFF_FFFF;
  localparam logic [UqW-1:0] MIN_SMOOTH   = 31'd7;
  localparam logic [UqW-1:0] UQ_MAX       = 31'h7FFF_FFFF;

  // polynomial coefficients 0.48 and 0.235 in Q16.16, and 1.0
  localparam logic [15:0] C_048  = 16'd31457;
  localparam logic [15:0] C_0235 = 16'd15401;
  localparam logic [16:0] ONE_Q  = 17'd65536;

  // iteration counts of the divide / root unit
  localparam logic [CntW-1:0] CNT_OMEGA = 7'd34;
  localparam logic [CntW-1:0] CNT_E     = 7'd33;
  localparam logic [CntW-1:0] CNT_SCALE = 7'd62;
  localparam logic [CntW-1:0] CNT_SQRT  = 7'd32;

  // one item after classification
  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic [DtW-1:0]     dt;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
  } cds2d_item_t;

  // request to the divide / root unit
  typedef struct packed {
    logic            start;
    logic            is_sqrt;
    logic [63:0]     num;
    logic [31:0]     den;
    logic [CntW-1:0] cnt;
  } cds2d_iter_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_OMEGA, ST_X, ST_X2, ST_X3, ST_T1, ST_T2, ST_E, ST_LIM,
    ST_SQX, ST_SQY, ST_LEN, ST_SCX, ST_DVX, ST_SCY, ST_DVY, ST_WX, ST_WY,
    ST_TMX, ST_TMY, ST_RX, ST_RY, ST_UX, ST_UY, ST_VX, ST_VY, ST_PX, ST_PY,
    ST_DONE
  } cds2d_state_e;

endpackage

// ===== design/critically_damped_smoothing_2d.sv =====
// ----------------------------------------------------------------------------
// critically_damped_smoothing_2d
// Critically damped 2D smoothing toward a target, Q16.16, with velocity state.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   in        in_valid_i / in_stall_o    current_x/y, target_x/y, step_time
//   out       out_valid_o / out_stall_i  next_x/y, speed_x/y, snapped
//   cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Items are worked one at a time. The shared divide/root unit works one bit per
// cycle for omega, the decay factor, the length and, when the offset is
// length-limited, the two scaled components; all products go through the
// shared multiplier.
// Asynchronous active-low reset clears velocity, queue and control.
// The input queue keeps taking items while the back end works or is stalled, until it is full.
// ----------------------------------------------------------------------------
`include "critically_damped_smoothing_2d_macros.svh"

module critically_damped_smoothing_2d #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cds2d_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                current_x_i,
  input  logic signed [31:0]                current_y_i,
  input  logic signed [31:0]                target_x_i,
  input  logic signed [31:0]                target_y_i,
  input  logic [16:0]                       step_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                next_x_o,
  output logic signed [31:0]                next_y_o,
  output logic signed [31:0]                speed_x_o,
  output logic signed [31:0]                speed_y_o,
  output logic                              snapped_o
);
  import cds2d_pkg::*;

  logic            item_valid, item_pop, iter_busy;
  cds2d_item_t     item;
  cds2d_iter_req_t iter_req;
  logic [63:0]     iter_res;
  logic [UqW-1:0]  smooth_time_q, max_speed_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_time_q <= SMOOTH_RESET;
      max_speed_q   <= SPEED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SMOOTH_TIME: smooth_time_q <= cfg_data_i[UqW-1:0];
        REG_MAX_SPEED:   max_speed_q   <= cfg_data_i[UqW-1:0];
        default: ;
      endcase
    end
  end

  cds2d_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .current_x_i  (current_x_i),
    .current_y_i  (current_y_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .step_time_i  (step_time_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  cds2d_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .busy_o (iter_busy),
    .res_o  (iter_res)
  );

  cds2d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .smooth_time_i (smooth_time_q),
    .max_speed_i   (max_speed_q),
    .iter_req_o    (iter_req),
    .iter_busy_i   (iter_busy),
    .iter_res_i    (iter_res),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_x_o      (next_x_o),
    .next_y_o      (next_y_o),
    .speed_x_o     (speed_x_o),
    .speed_y_o     (speed_y_o),
    .snapped_o     (snapped_o)
  );

  // checks
  `CDS_ASSERT_NOW(a_pop_needs_item, item_pop, item_valid, "pop from empty queue")
  `CDS_ASSERT_NOW(a_snap_clears_speed, out_valid_o && snapped_o, speed_x_o == '0 && speed_y_o == '0, "snap with nonzero speed")
  `CDS_ASSERT_NEXT(a_cfg_smooth, cfg_valid_i && cfg_ready_o && cfg_index_i == REG_SMOOTH_TIME, smooth_time_q == $past(cfg_data_i[UqW-1:0]), "smooth_time not written")

endmodule

// ===== design/cds2d_front.sv =====
// ----------------------------------------------------------------------------
// cds2d_front
// Accepts items, forms the saturated target offsets, queues them.
// ----------------------------------------------------------------------------
module cds2d_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [31:0]       current_x_i,
  input  logic signed [31:0]       current_y_i,
  input  logic signed [31:0]       target_x_i,
  input  logic signed [31:0]       target_y_i,
  input  logic [16:0]              step_time_i,
  output logic                     item_valid_o,
  output cds2d_pkg::cds2d_item_t   item_o,
  input  logic                     item_pop_i
);
  import cds2d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumW = $clog2(Depth + 1);

  cds2d_item_t       mem_q [Depth];
  cds2d_item_t       item_in;
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [NumW-1:0]   num_q;
  logic              push;

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return d[31:0];
  endfunction

  // classify: offset to target
  always_comb begin
    item_in.cur_x = current_x_i;
    item_in.cur_y = current_y_i;
    item_in.tgt_x = target_x_i;
    item_in.tgt_y = target_y_i;
    item_in.dt    = step_time_i;
    item_in.off_x = sat_diff(target_x_i, current_x_i);
    item_in.off_y = sat_diff(target_y_i, current_y_i);
  end

  assign in_stall_o   = (num_q == NumW'(Depth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (num_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_in;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (item_pop_i) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !item_pop_i) num_q <= num_q + 1'b1;
      else if (!push && item_pop_i) num_q <= num_q - 1'b1;
    end
  end

endmodule

// ===== design/cds2d_iter.sv =====
// ----------------------------------------------------------------------------
// cds2d_iter
// Shared radix-2 divider and digit-by-digit square root, one bit per cycle.
// ----------------------------------------------------------------------------
module cds2d_iter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cds2d_pkg::cds2d_iter_req_t  req_i,
  output logic                        busy_o,
  output logic [63:0]                 res_o
);
  import cds2d_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sqrt_q;
  logic [31:0]     den_q;
  logic [63:0]     sh_q, sh_d;
  logic [33:0]     rem_q, rem_d;
  logic [31:0]     root_q, root_d;
  logic [32:0]     dv_r;
  logic [35:0]     sq_r, sq_t;

  // one step; dividend is top-aligned and quotient bits shift in at the bottom
  always_comb begin
    dv_r   = {rem_q[31:0], sh_q[63]};
    sq_r   = {rem_q, sh_q[63:62]};
    sq_t   = {2'b00, root_q, 2'b01};
    sh_d   = sh_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      sh_d   = req_i.num;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = req_i.cnt;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (sqrt_q) begin
        sh_d = {sh_q[61:0], 2'b00};
        if (sq_r >= sq_t) begin
          rem_d  = 34'(sq_r - sq_t);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = sq_r[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
      end else begin
        if (dv_r >= {1'b0, den_q}) begin
          rem_d = {2'b00, 32'(dv_r - {1'b0, den_q})};
          sh_d  = {sh_q[62:0], 1'b1};
        end else begin
          rem_d = {2'b00, dv_r[31:0]};
          sh_d  = {sh_q[62:0], 1'b0};
        end
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign res_o  = sqrt_q ? {32'd0, root_q} : sh_q;

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      den_q  <= req_i.den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

endmodule

// ===== design/cds2d_back.sv =====
// ----------------------------------------------------------------------------
// cds2d_back
// Sequencer for one item: shared 33x33 multiplier, divide/root requests,
// velocity state and the output register.
// ----------------------------------------------------------------------------
module cds2d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  cds2d_pkg::cds2d_item_t      item_i,
  output logic                        item_pop_o,
  input  logic [30:0]                 smooth_time_i,
  input  logic [30:0]                 max_speed_i,
  output cds2d_pkg::cds2d_iter_req_t  iter_req_o,
  input  logic                        iter_busy_i,
  input  logic [63:0]                 iter_res_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          next_x_o,
  output logic signed [31:0]          next_y_o,
  output logic signed [31:0]          speed_x_o,
  output logic signed [31:0]          speed_y_o,
  output logic                        snapped_o
);
  import cds2d_pkg::*;

  cds2d_state_e       state_q, state_d;
  logic               ph_q, ph_d;
  logic               advance, out_load, iter_state, len_gt;

  cds2d_item_t        item_q;
  logic [30:0]        st_q, om_q, x_q, x2_q, x3_q, den_q, lim_q;
  logic [33:0]        acc_q, den_sum;
  logic [16:0]        e_q;
  logic [63:0]        sq_q;
  logic [31:0]        len_q, quo, abs_dx, abs_dy;
  logic signed [31:0] dx_q, dy_q, wx_q, wy_q, tmx_q, tmy_q, rx_q, ry_q;
  logic signed [31:0] ux_q, uy_q, nvx_q, nvy_q, vel_x_q, vel_y_q, s_new;
  logic signed [64:0] pacc_q;
  logic               snap_q;
  logic signed [32:0] ma_q, mb_q;
  logic signed [65:0] p_q;
  logic [30:0]        u_new;

  logic               out_valid_q, snapped_q;
  logic signed [31:0] next_x_q, next_y_q, speed_x_q, speed_y_q;

  function automatic logic signed [65:0] sx(input logic signed [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic logic signed [31:0] sat_w(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [32:0] m_s(input logic signed [31:0] a);
    return {a[31], a};
  endfunction

  function automatic logic signed [32:0] m_u(input logic [30:0] a);
    return {2'b00, a};
  endfunction

  function automatic logic signed [32:0] m_dt(input logic [16:0] a);
    return {16'd0, a};
  endfunction

  // product post-processing: unsigned saturate, and signed floor + saturate
  always_comb begin
    logic signed [65:0] sh;
    sh      = p_q >>> 16;
    u_new   = (sh > 66'sd2147483647) ? UQ_MAX : sh[30:0];
    s_new   = sat_w(sh);
    den_sum = acc_q + {3'b000, u_new};
    quo     = iter_res_i[31:0];
    abs_dx  = dx_q[31] ? 32'(-dx_q) : dx_q;
    abs_dy  = dy_q[31] ? 32'(-dy_q) : dy_q;
    len_gt  = (iter_res_i[31:0] > {1'b0, lim_q});
  end

  assign iter_state = (state_q == ST_OMEGA) || (state_q == ST_E) || (state_q == ST_LEN) ||
                      (state_q == ST_DVX) || (state_q == ST_DVY);

  // next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_OMEGA;
          ph_d    = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else if (advance) begin
          ph_d = 1'b0;
          case (state_q)
            ST_OMEGA: state_d = ST_X;
            ST_X:     state_d = ST_X2;
            ST_X2:    state_d = ST_X3;
            ST_X3:    state_d = ST_T1;
            ST_T1:    state_d = ST_T2;
            ST_T2:    state_d = ST_E;
            ST_E:     state_d = ST_LIM;
            ST_LIM:   state_d = ST_SQX;
            ST_SQX:   state_d = ST_SQY;
            ST_SQY:   state_d = ST_LEN;
            ST_LEN:   state_d = len_gt ? ST_SCX : ST_WX;
            ST_SCX:   state_d = ST_DVX;
            ST_DVX:   state_d = ST_SCY;
            ST_SCY:   state_d = ST_DVY;
            ST_DVY:   state_d = ST_WX;
            ST_WX:    state_d = ST_WY;
            ST_WY:    state_d = ST_TMX;
            ST_TMX:   state_d = ST_TMY;
            ST_TMY:   state_d = ST_RX;
            ST_RX:    state_d = ST_RY;
            ST_RY:    state_d = ST_UX;
            ST_UX:    state_d = ST_UY;
            ST_UY:    state_d = ST_VX;
            ST_VX:    state_d = ST_VY;
            ST_VY:    state_d = ST_PX;
            ST_PX:    state_d = ST_PY;
            ST_PY:    state_d = ST_DONE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // control outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    advance    = ph_q && !(iter_state && iter_busy_i);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    iter_req_o         = '0;
    iter_req_o.start   = !ph_q && iter_state;
    case (state_q)
      ST_OMEGA: begin
        iter_req_o.num = {1'b1, 63'd0};
        iter_req_o.den = {1'b0, st_q};
        iter_req_o.cnt = CNT_OMEGA;
      end
      ST_E: begin
        iter_req_o.num = {1'b1, 63'd0};
        iter_req_o.den = {1'b0, den_q};
        iter_req_o.cnt = CNT_E;
      end
      ST_LEN: begin
        iter_req_o.is_sqrt = 1'b1;
        iter_req_o.num     = sq_q;
        iter_req_o.cnt     = CNT_SQRT;
      end
      ST_DVX, ST_DVY: begin
        iter_req_o.num = {p_q[61:0], 2'b00};
        iter_req_o.den = len_q;
        iter_req_o.cnt = CNT_SCALE;
      end
      default: ;
    endcase
  end

  // datapath: multiplier runs every cycle, results taken on the second phase
  always_ff @(posedge clk_i) begin
    p_q <= ma_q * mb_q;
    if (item_pop_o) begin
      item_q <= item_i;
      st_q   <= (smooth_time_i < MIN_SMOOTH) ? MIN_SMOOTH : smooth_time_i;
      dx_q   <= item_i.off_x;
      dy_q   <= item_i.off_y;
    end
    if (advance) begin
      case (state_q)
        ST_OMEGA: begin
          om_q <= iter_res_i[30:0];
          ma_q <= m_u(iter_res_i[30:0]);
          mb_q <= m_dt(item_q.dt);
        end
        ST_X: begin
          x_q  <= u_new;
          ma_q <= m_u(u_new);
          mb_q <= m_u(u_new);
        end
        ST_X2: begin
          x2_q <= u_new;
          ma_q <= m_u(u_new);
          mb_q <= m_u(x_q);
        end
        ST_X3: begin
          x3_q <= u_new;
          ma_q <= {17'd0, C_048};
          mb_q <= m_u(x2_q);
        end
        ST_T1: begin
          acc_q <= {17'd0, ONE_Q} + {3'b000, x_q} + {3'b000, u_new};
          ma_q  <= {17'd0, C_0235};
          mb_q  <= m_u(x3_q);
        end
        ST_T2: den_q <= (den_sum > {3'b000, UQ_MAX}) ? UQ_MAX : den_sum[30:0];
        ST_E: begin
          e_q  <= iter_res_i[16:0];
          ma_q <= m_u(max_speed_i);
          mb_q <= m_u(st_q);
        end
        ST_LIM: begin
          lim_q <= u_new;
          ma_q  <= m_s(dx_q);
          mb_q  <= m_s(dx_q);
        end
        ST_SQX: begin
          sq_q <= p_q[63:0];
          ma_q <= m_s(dy_q);
          mb_q <= m_s(dy_q);
        end
        ST_SQY: sq_q <= sq_q + p_q[63:0];
        ST_LEN: begin
          len_q <= iter_res_i[31:0];
          if (len_gt) begin
            ma_q <= {1'b0, abs_dx};
            mb_q <= m_u(lim_q);
          end else begin
            ma_q <= m_u(om_q);
            mb_q <= m_s(dx_q);
          end
        end
        ST_DVX: begin
          dx_q <= dx_q[31] ? 32'(-quo) : quo;
          ma_q <= {1'b0, abs_dy};
          mb_q <= m_u(lim_q);
        end
        ST_DVY: begin
          dy_q <= dy_q[31] ? 32'(-quo) : quo;
          ma_q <= m_u(om_q);
          mb_q <= m_s(dx_q);
        end
        ST_WX: begin
          wx_q <= s_new;
          ma_q <= m_u(om_q);
          mb_q <= m_s(dy_q);
        end
        ST_WY: begin
          wy_q <= s_new;
          ma_q <= m_s(sat_w(sx(vel_x_q) + sx(wx_q)));
          mb_q <= m_dt(item_q.dt);
        end
        ST_TMX: begin
          tmx_q <= s_new;
          ma_q  <= m_s(sat_w(sx(vel_y_q) + sx(wy_q)));
          mb_q  <= m_dt(item_q.dt);
        end
        ST_TMY: begin
          tmy_q <= s_new;
          ma_q  <= m_s(sat_w(sx(dx_q) + sx(tmx_q)));
          mb_q  <= m_dt(e_q);
        end
        ST_RX: begin
          rx_q <= sat_w(sx(item_q.cur_x) - sx(dx_q) + sx(s_new));
          ma_q <= m_s(sat_w(sx(dy_q) + sx(tmy_q)));
          mb_q <= m_dt(e_q);
        end
        ST_RY: begin
          ry_q <= sat_w(sx(item_q.cur_y) - sx(dy_q) + sx(s_new));
          ma_q <= m_u(om_q);
          mb_q <= m_s(tmx_q);
        end
        ST_UX: begin
          ux_q <= sat_w(sx(vel_x_q) - sx(s_new));
          ma_q <= m_u(om_q);
          mb_q <= m_s(tmy_q);
        end
        ST_UY: begin
          uy_q <= sat_w(sx(vel_y_q) - sx(s_new));
          ma_q <= m_s(ux_q);
          mb_q <= m_dt(e_q);
        end
        ST_VX: begin
          nvx_q <= s_new;
          ma_q  <= m_s(uy_q);
          mb_q  <= m_dt(e_q);
        end
        ST_VY: begin
          nvy_q <= s_new;
          ma_q  <= m_s(item_q.off_x);
          mb_q  <= m_s(sat_w(sx(rx_q) - sx(item_q.tgt_x)));
        end
        ST_PX: begin
          pacc_q <= {p_q[63], p_q[63:0]};
          ma_q   <= m_s(item_q.off_y);
          mb_q   <= m_s(sat_w(sx(ry_q) - sx(item_q.tgt_y)));
        end
        // overshoot when the dot product of offset and miss is positive
        ST_PY: snap_q <= (pacc_q + $signed({p_q[63], p_q[63:0]})) > 65'sd0;
        default: ;
      endcase
    end
    if (out_load) begin
      next_x_q  <= snap_q ? item_q.tgt_x : rx_q;
      next_y_q  <= snap_q ? item_q.tgt_y : ry_q;
      speed_x_q <= snap_q ? '0 : nvx_q;
      speed_y_q <= snap_q ? '0 : nvy_q;
      snapped_q <= snap_q;
    end
  end

  // control state and velocity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        vel_x_q     <= snap_q ? '0 : nvx_q;
        vel_y_q     <= snap_q ? '0 : nvy_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_x_o    = next_x_q;
  assign next_y_o    = next_y_q;
  assign speed_x_o   = speed_x_q;
  assign speed_y_o   = speed_y_q;
  assign snapped_o   = snapped_q;

endmodule
